@@ src/mma_pkg.sv @@
// Package: sizes, payload structs, lane control and state encoding for the moving average unit.
package mma_pkg;

  localparam int unsigned WINDOW   = 8;
  localparam int unsigned CHANNELS = 4;
  localparam int unsigned DATA_W   = 16;

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = DATA_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
  localparam int unsigned ACC_W  = SUM_W + 1;
  localparam int unsigned ITER   = (SUM_W + 1) / 2;
  localparam int unsigned DIV_W  = 2 * ITER;
  localparam int unsigned REM_W  = CNT_W + 1;
  localparam int unsigned ITER_W = (ITER > 1) ? $clog2(ITER) : 1;

  localparam logic [DATA_W-1:0] NO_RETURN     = 16'hFFFF;
  localparam logic [DATA_W-1:0] MAX_RANGE_RST = 16'd3500;

  typedef struct packed {
    logic              restart;
    logic [DATA_W-1:0] range_0;
    logic [DATA_W-1:0] range_1;
    logic [DATA_W-1:0] range_2;
    logic [DATA_W-1:0] range_3;
  } mma_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] avg_0;
    logic [DATA_W-1:0] avg_1;
    logic [DATA_W-1:0] avg_2;
    logic [DATA_W-1:0] avg_3;
  } mma_out_t;

  typedef struct packed {
    logic              start;
    logic              clear;
    logic              warm;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
    logic              step;
  } mma_lane_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } mma_state_e;

endpackage

@@ src/multichannel_moving_average_unit.sv @@
// Top level: window control, channel lanes and merged output register.
//
//   channel | direction | handshake            | word
//   in      | in        | in_valid_i/in_stall_o  | mma_in_t: restart, range_0..range_3
//   out     | out       | out_valid_o/out_stall_i| mma_out_t: avg_0..avg_3
//   cfg     | in        | cfg_valid_i/cfg_ready_o| max_range, 16 bits
//
// Each word is accepted in ST_IDLE, divided in ST_DIV with the lane dividers retiring two quotient
// bits per step, and loaded into the output register in ST_DONE; the input stalls outside ST_IDLE.
// The next input word is taken while a finished result waits in the output register.
// A stalled output holds the finished lane results until the register frees.
// Reset clears control state and sets max_range to 3500; the first word restarts the window.
module multichannel_moving_average_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  mma_pkg::mma_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output mma_pkg::mma_out_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mma_pkg::DATA_W-1:0]  cfg_data_i
);
  import mma_pkg::*;

  mma_state_e        state_q, state_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              warm_q, warm_d;
  logic              never_q, never_d;
  logic [DATA_W-1:0] max_range_q;
  logic              out_valid_q, out_valid_d;
  mma_out_t          out_q;
  mma_out_t          merged;
  logic              accept, load, out_free, restart_eff, step;
  mma_lane_ctrl_t    ctrl;
  logic [DATA_W-1:0] lane_in  [CHANNELS];
  logic [DATA_W-1:0] lane_avg [CHANNELS];

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign restart_eff = in_data_i.restart || never_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ITER_W'(ITER - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    step       = 1'b0;
    load       = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_DIV:  step       = 1'b1;
      ST_DONE: load       = out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    slot_d  = slot_q;
    warm_d  = warm_q;
    never_d = never_q;
    if (accept) begin
      if (restart_eff) begin
        slot_d  = '0;
        warm_d  = 1'b1;
        never_d = 1'b0;
      end else if (slot_q == SLOT_W'(WINDOW - 1)) begin
        slot_d = '0;
        warm_d = 1'b0;
      end else begin
        slot_d = slot_q + 1'b1;
      end
    end
  end

  assign ctrl.start = accept;
  assign ctrl.clear = restart_eff;
  assign ctrl.warm  = warm_d;
  assign ctrl.slot  = slot_d;
  assign ctrl.count = warm_d ? (CNT_W'(slot_d) + CNT_W'(1)) : CNT_W'(WINDOW);
  assign ctrl.step  = step;

  assign lane_in[0] = in_data_i.range_0;
  assign lane_in[1] = in_data_i.range_1;
  assign lane_in[2] = in_data_i.range_2;
  assign lane_in[3] = in_data_i.range_3;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    mma_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .max_range_i (max_range_q),
      .sample_i    (lane_in[c]),
      .avg_o       (lane_avg[c])
    );
  end

  assign merged.avg_0 = lane_avg[0];
  assign merged.avg_1 = lane_avg[1];
  assign merged.avg_2 = lane_avg[2];
  assign merged.avg_3 = lane_avg[3];

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      slot_q      <= '0;
      warm_q      <= 1'b1;
      never_q     <= 1'b1;
      max_range_q <= MAX_RANGE_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      slot_q      <= slot_d;
      warm_q      <= warm_d;
      never_q     <= never_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_range_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= merged;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/mma_lane.sv @@
// One channel lane: sample ring, running sum and two-bit-per-cycle divider that advances while step is set.
module mma_lane (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mma_pkg::mma_lane_ctrl_t      ctrl_i,
  input  logic [mma_pkg::DATA_W-1:0]   max_range_i,
  input  logic [mma_pkg::DATA_W-1:0]   sample_i,
  output logic [mma_pkg::DATA_W-1:0]   avg_o
);
  import mma_pkg::*;

  logic [DATA_W-1:0] ring_q [WINDOW];
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [DIV_W-1:0]  dq_q, dq_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  divisor_q;
  logic [DATA_W-1:0] sample;
  logic [DATA_W-1:0] old;
  logic [ACC_W-1:0]  acc;

  assign sample = (sample_i == NO_RETURN) ? max_range_i : sample_i;
  assign old    = ring_q[ctrl_i.slot];

  always_comb begin
    if (ctrl_i.clear) begin
      acc = ACC_W'(sample);
    end else if (ctrl_i.warm) begin
      acc = ACC_W'(sum_q) + ACC_W'(sample);
    end else begin
      acc = ACC_W'(sum_q) + ACC_W'(sample) - ACC_W'(old);
    end
    sum_d = acc[SUM_W-1:0];
  end

  always_comb begin
    logic [REM_W-1:0] r;
    logic [DIV_W-1:0] d;
    r = rem_q;
    d = dq_q;
    for (int k = 0; k < 2; k++) begin
      r = {r[REM_W-2:0], d[DIV_W-1]};
      d = {d[DIV_W-2:0], 1'b0};
      if (r >= REM_W'(divisor_q)) begin
        r    = r - REM_W'(divisor_q);
        d[0] = 1'b1;
      end
    end
    rem_d = r;
    dq_d  = d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.start) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      ring_q[ctrl_i.slot] <= sample;
      dq_q                <= DIV_W'(sum_d);
      rem_q               <= '0;
      divisor_q           <= ctrl_i.count;
    end else if (ctrl_i.step) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign avg_o = dq_q[DATA_W-1:0];

endmodule

@@ src/mma_checker.sv @@
// Port checker for the moving average unit, bound to the top level.
module mma_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input mma_pkg::mma_in_t            in_data_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input mma_pkg::mma_out_t           out_data_o,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [mma_pkg::DATA_W-1:0]  cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while one is being averaged");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared before the division finished");

endmodule

bind multichannel_moving_average_unit mma_checker u_mma_checker (.*);

@@ tb/multichannel_moving_average_unit_tb.sv @@
// Testbench: per-channel moving average of scanner ranges checked against a predictor.
module multichannel_moving_average_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mma_pkg::*;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  mma_in_t           in_word     = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  mma_out_t          out_word;
  logic              cfg_valid   = 1'b0;
  logic              cfg_ready;
  logic [DATA_W-1:0] cfg_data    = '0;

  // predictor state
  logic [DATA_W-1:0] ring [WINDOW][CHANNELS];
  logic [DATA_W-1:0] range_cap = MAX_RANGE_RST;
  int unsigned       slot      = 0;
  bit                warm      = 1'b1;
  bit                virgin    = 1'b1;

  mma_in_t  scan_queue [$];
  mma_out_t avg_due [$];
  int       faults = 0;
  bit       calm   = 1'b0;

  multichannel_moving_average_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  function automatic mma_out_t filter_scan(mma_in_t w);
    logic [DATA_W-1:0] s;
    logic [31:0]       total;
    int unsigned       n;
    mma_out_t          r;
    r = '0;
    if (w.restart || virgin) begin
      foreach (ring[i, c]) ring[i][c] = '0;
      warm   = 1'b1;
      slot   = 0;
      virgin = 1'b0;
    end else begin
      slot++;
      if (slot >= WINDOW) begin
        slot = 0;
        warm = 1'b0;
      end
    end
    for (int c = 0; c < CHANNELS; c++) begin
      s = w[(CHANNELS-1-c)*DATA_W +: DATA_W];
      if (s == NO_RETURN) s = range_cap;
      ring[slot][c] = s;
    end
    n = warm ? slot + 1 : WINDOW;
    for (int c = 0; c < CHANNELS; c++) begin
      total = '0;
      for (int i = 0; i < n; i++) total += ring[i][c];
      r[(CHANNELS-1-c)*DATA_W +: DATA_W] = DATA_W'(total / n);
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_range();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return NO_RETURN;
    if (roll < 18) return '0;
    if (roll < 25) return 16'd65534;
    if (roll < 40) return DATA_W'($urandom_range(0, 255));
    return DATA_W'($urandom_range(0, 65535));
  endfunction

  task automatic push_scan(input bit rs, input logic [DATA_W-1:0] a, b, c, d);
    mma_in_t w;
    w.restart = rs;
    w.range_0 = a;
    w.range_1 = b;
    w.range_2 = c;
    w.range_3 = d;
    scan_queue.push_back(w);
  endtask

  task automatic fill_random(input int n, input int restart_odds);
    for (int k = 0; k < n; k++)
      push_scan($urandom_range(0, restart_odds - 1) == 0,
                pick_range(), pick_range(), pick_range(), pick_range());
  endtask

  task automatic drain();
    while (scan_queue.size() != 0 || in_valid || avg_due.size() != 0) @(negedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_range_cap(input logic [DATA_W-1:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    range_cap = v;
  endtask

  // driver: advance the queue once the current word is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) avg_due.push_back(filter_scan(in_word));
      if (!in_valid || !in_stall) begin
        if (scan_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 13)) begin
          in_word  <= scan_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 13);
    end
  end

  always @(posedge clk_i) begin : monitor
    mma_out_t          want;
    logic [DATA_W-1:0] w_avg, g_avg;
    if (rst_ni && out_valid && !out_stall) begin
      if (avg_due.size() == 0) begin
        $error("unexpected result word %h", out_word);
        faults++;
      end else begin
        want = avg_due.pop_front();
        for (int c = 0; c < CHANNELS; c++) begin
          w_avg = want[(CHANNELS-1-c)*DATA_W +: DATA_W];
          g_avg = out_word[(CHANNELS-1-c)*DATA_W +: DATA_W];
          if (w_avg !== g_avg) begin
            $error("avg_%0d: expected %0d, got %0d", c, w_avg, g_avg);
            faults++;
          end
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_scan(1'b0, 16'd100, 16'd200, 16'd300, 16'd400);
    push_scan(1'b0, 16'd0, 16'd65534, NO_RETURN, 16'd1);
    push_scan(1'b0, 16'd65534, 16'd65534, 16'd65534, 16'd65534);
    push_scan(1'b0, NO_RETURN, NO_RETURN, NO_RETURN, NO_RETURN);
    for (int k = 0; k < 7; k++)
      push_scan(1'b0, pick_range(), pick_range(), pick_range(), pick_range());
    push_scan(1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
    push_scan(1'b1, NO_RETURN, 16'd7, 16'd65534, 16'd0);
    for (int k = 0; k < 9; k++)
      push_scan(1'b0, 16'd65534, 16'd65534, 16'd65534, 16'd65534);
    fill_random(300, 25);
    drain();

    write_range_cap(16'hFFFF);
    for (int k = 0; k < 10; k++) push_scan(1'b0, NO_RETURN, NO_RETURN, NO_RETURN, NO_RETURN);
    fill_random(270, 25);
    drain();

    write_range_cap(16'd0);
    fill_random(280, 20);
    drain();

    calm = 1'b1;
    write_range_cap(16'd65534);
    fill_random(280, 30);
    drain();
    calm = 1'b0;

    write_range_cap(DATA_W'($urandom_range(0, 65535)));
    fill_random(280, 6);
    drain();

    write_range_cap(DATA_W'($urandom_range(0, 65535)));
    fill_random(280, 40);
    drain();

    repeat (20) @(posedge clk_i);
    if (faults == 0 && avg_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
src/mma_pkg.sv
src/mma_lane.sv
src/multichannel_moving_average_unit.sv
src/mma_checker.sv
tb/multichannel_moving_average_unit_tb.sv
